/* hw/rtl/text_word_extractor_defines.svh */
// Assertion macros shared by the word extractor modules.
`ifndef TEXT_WORD_EXTRACTOR_DEFINES_SVH
`define TEXT_WORD_EXTRACTOR_DEFINES_SVH

// Same-cycle implication, checked on every clk edge outside reset.
`define TWE_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every clk edge outside reset.
`define TWE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/twe_pkg.sv */
// Shared constants, byte classifier and types for the word extractor.
`timescale 1ns / 1ps
package twe_pkg;

  // Longest stored word and derived widths (two word buffers in one RAM)
  localparam int WORD_MAX  = 63;
  localparam int IDX_W     = $clog2(WORD_MAX + 1);
  localparam int ADDR_W    = IDX_W + 1;
  localparam int RAM_DEPTH = 2 ** ADDR_W;

  // Character codes
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_APOS  = 8'h27;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_D0    = 8'h30;
  localparam logic [7:0] CH_D9    = 8'h39;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_QUEST = 8'h3F;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7A;

  typedef logic [2:0] cls_t;

  // Byte classes
  localparam cls_t CLS_SPECIAL = 3'd0;
  localparam cls_t CLS_APOS    = 3'd1;
  localparam cls_t CLS_PUNCT   = 3'd2;
  localparam cls_t CLS_DIGIT   = 3'd3;
  localparam cls_t CLS_LETTER  = 3'd4;

  // Letter tally saturates here
  localparam logic [1:0] TALLY_MIN = 2'd2;

  function automatic cls_t byte_class(input logic [7:0] b);
    cls_t c;
    if ((b >= CH_LA && b <= CH_LZ) || (b >= CH_UA && b <= CH_UZ)) begin
      c = CLS_LETTER;
    end else if (b >= CH_D0 && b <= CH_D9) begin
      c = CLS_DIGIT;
    end else if (b == CH_APOS || b == CH_AMP || b == CH_BS) begin
      c = CLS_APOS;
    end else if (b == CH_DOT || b == CH_COMMA || b == CH_SEMI ||
                 b == CH_QUEST || b == CH_COLON) begin
      c = CLS_PUNCT;
    end else begin
      c = CLS_SPECIAL;
    end
    return c;
  endfunction

  // Trailing bytes dropped from a word (backspace is kept)
  function automatic logic is_strippable(input logic [7:0] b);
    return (b == CH_APOS) || (b == CH_AMP) || (byte_class(b) == CLS_PUNCT);
  endfunction

  // A finished word waiting for emission
  typedef struct packed {
    logic             bank;
    logic [IDX_W-1:0] keep;
    logic             cut;
  } job_t;

  // Back end releases a word buffer
  typedef struct packed {
    logic valid;
    logic bank;
  } done_t;

  // One result word
  typedef struct packed {
    logic [7:0] data;
    logic       word_end;
    logic       word_cut;
  } res_t;

endpackage

/* hw/rtl/twe_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module twe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hw/rtl/twe_job_fifo.sv */
// Two-entry queue of finished words between the front and back ends.
`timescale 1ns / 1ps
module twe_job_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  twe_pkg::job_t wdata,
  output logic          full,
  output logic          valid,
  output twe_pkg::job_t rdata,
  input  logic          pop
);

  twe_pkg::job_t mem [2];
  logic          wptr;
  logic          rptr;
  logic [1:0]    cnt;

  assign full  = (cnt == 2'd2);
  assign valid = (cnt != 2'd0);
  assign rdata = mem[rptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      cnt  <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop)  rptr <= ~rptr;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wdata;
    end
  end

endmodule

/* hw/rtl/twe_front.sv */
// Front end: classifies input bytes, fills a word buffer, hands off words.
`timescale 1ns / 1ps
`include "text_word_extractor_defines.svh"
module twe_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [7:0]                 text_byte,
  output logic                       full,
  output logic                       job_push,
  output twe_pkg::job_t              job,
  input  logic                       job_full,
  input  twe_pkg::done_t             done,
  output logic                       ram_we,
  output logic [twe_pkg::ADDR_W-1:0] ram_waddr,
  output logic [7:0]                 ram_wdata
);

  logic                      cur_bank;
  logic [1:0]                bank_busy;
  logic [twe_pkg::IDX_W-1:0] stored_len;
  logic [twe_pkg::IDX_W-1:0] keep_len;
  logic [1:0]                letter_tally;
  logic                      inside_word;
  logic                      overflowed;

  logic                      accept;
  twe_pkg::cls_t             cls;
  logic                      is_word;
  logic                      is_letter;
  logic                      store_ok;
  logic                      extend;
  logic                      close;
  logic [twe_pkg::IDX_W-1:0] len_inc;

  // stall while the current buffer still drains or the queue is full
  assign full   = bank_busy[cur_bank] | job_full;
  assign accept = push & ~full;

  // classify
  assign cls       = twe_pkg::byte_class(text_byte);
  assign is_letter = (cls == twe_pkg::CLS_LETTER);
  assign is_word   = is_letter | (cls == twe_pkg::CLS_DIGIT);
  assign store_ok  = (stored_len < twe_pkg::IDX_W'(twe_pkg::WORD_MAX));
  assign len_inc   = stored_len + twe_pkg::IDX_W'(1);

  // open or grow a word; a special byte closes it
  assign extend = accept & (inside_word ? (cls != twe_pkg::CLS_SPECIAL) : is_word);
  assign close  = accept & inside_word & (cls == twe_pkg::CLS_SPECIAL);

  assign ram_we    = extend & store_ok;
  assign ram_waddr = {cur_bank, stored_len};
  assign ram_wdata = text_byte;

  // only words with at least two letters go to the back end
  assign job_push = close & (letter_tally == twe_pkg::TALLY_MIN);
  assign job.bank = cur_bank;
  assign job.keep = keep_len;
  assign job.cut  = overflowed;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_bank     <= 1'b0;
      bank_busy    <= 2'b00;
      stored_len   <= '0;
      keep_len     <= '0;
      letter_tally <= 2'd0;
      inside_word  <= 1'b0;
      overflowed   <= 1'b0;
    end else begin
      if (done.valid) begin
        bank_busy[done.bank] <= 1'b0;
      end
      if (close) begin
        inside_word  <= 1'b0;
        stored_len   <= '0;
        keep_len     <= '0;
        letter_tally <= 2'd0;
        overflowed   <= 1'b0;
        if (job_push) begin
          bank_busy[cur_bank] <= 1'b1;
          cur_bank            <= ~cur_bank;
        end
      end else if (extend) begin
        inside_word <= 1'b1;
        if (is_letter && letter_tally != twe_pkg::TALLY_MIN) begin
          letter_tally <= letter_tally + 2'd1;
        end
        if (store_ok) begin
          stored_len <= len_inc;
          if (!twe_pkg::is_strippable(text_byte)) begin
            keep_len <= len_inc;
          end
        end else begin
          overflowed <= 1'b1;
        end
      end
    end
  end

  `TWE_ASSERT_SAME(a_push_room, job_push, !job_full, "word handed off to a full queue")
  `TWE_ASSERT_SAME(a_wr_free, ram_we, !bank_busy[cur_bank], "write into a draining buffer")
  `TWE_ASSERT_SAME(a_len_order, 1'b1,
                   keep_len <= stored_len && stored_len <= twe_pkg::IDX_W'(twe_pkg::WORD_MAX),
                   "word length bookkeeping out of range")

endmodule

/* hw/rtl/twe_back.sv */
// Back end: reads finished words from the buffer and queues result words.
`timescale 1ns / 1ps
`include "text_word_extractor_defines.svh"
module twe_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       job_valid,
  input  twe_pkg::job_t              job_head,
  output logic                       job_pop,
  output twe_pkg::done_t             done,
  output logic                       ram_re,
  output logic [twe_pkg::ADDR_W-1:0] ram_raddr,
  input  logic [7:0]                 ram_rdata,
  output logic                       empty,
  input  logic                       pop,
  output twe_pkg::res_t              head
);

  logic [twe_pkg::IDX_W-1:0] rd_idx;
  logic                      pend;
  logic                      pend_end;
  logic                      pend_cut;
  twe_pkg::res_t             ofifo [2];
  logic                      wptr;
  logic                      rptr;
  logic [1:0]                ocnt;

  logic                      pop_fire;
  logic [1:0]                credit;
  logic                      issue;
  logic                      issue_end;
  twe_pkg::res_t             wr_res;

  assign empty    = (ocnt == 2'd0);
  assign pop_fire = pop & ~empty;
  assign head     = ofifo[rptr];

  // slots held or in flight after this cycle's pop
  assign credit    = ocnt + {1'b0, pend} - {1'b0, pop_fire};
  assign issue     = job_valid & (credit < 2'd2);
  assign issue_end = issue & (rd_idx == job_head.keep);

  assign ram_re    = issue & ~issue_end;
  assign ram_raddr = {job_head.bank, rd_idx};

  assign job_pop    = issue_end;
  assign done.valid = issue_end;
  assign done.bank  = job_head.bank;

  // result from the read in flight: stored byte or the closing newline
  always_comb begin
    if (pend_end) begin
      wr_res.data     = twe_pkg::CH_NL;
      wr_res.word_end = 1'b1;
      wr_res.word_cut = pend_cut;
    end else begin
      wr_res.data     = ram_rdata;
      wr_res.word_end = 1'b0;
      wr_res.word_cut = 1'b0;
    end
  end

  // read sequencer and result queue control
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx <= '0;
      pend   <= 1'b0;
      wptr   <= 1'b0;
      rptr   <= 1'b0;
      ocnt   <= 2'd0;
    end else begin
      if (issue) begin
        rd_idx <= issue_end ? '0 : rd_idx + twe_pkg::IDX_W'(1);
      end
      pend <= issue;
      if (pend)     wptr <= ~wptr;
      if (pop_fire) rptr <= ~rptr;
      ocnt <= ocnt + {1'b0, pend} - {1'b0, pop_fire};
    end
  end

  // payload
  always_ff @(posedge clk) begin
    pend_end <= issue_end;
    pend_cut <= job_head.cut;
    if (pend) begin
      ofifo[wptr] <= wr_res;
    end
  end

  `TWE_ASSERT_SAME(a_credit, 1'b1, ocnt + {1'b0, pend} <= 2'd2, "result queue overcommitted")
  `TWE_ASSERT_NEXT(a_landed, pend, ocnt != 2'd0, "read result lost")
  `TWE_ASSERT_SAME(a_idx, job_valid, rd_idx <= job_head.keep, "read index past word end")

endmodule

/* hw/rtl/text_word_extractor.sv */
// Top level of the text word extractor.
`timescale 1ns / 1ps
// Splits a byte stream into words that open with a letter or digit and
// emits each word holding at least two letters as one byte per result
// word, trailing apostrophes, ampersands and punctuation removed, followed
// by a newline word with word_end set (word_cut set if the word ran past
// 63 bytes). Input takes one byte per cycle; a word is stored in one of two
// buffers in a shared RAM while the back end emits the previous one at one
// result per cycle while results are popped, so a word of n kept bytes leaves
// as n+1 results. Input stalls only when both buffers hold words still
// waiting to be emitted. A closed word is queued, read from RAM, then emitted.
module text_word_extractor (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] text_byte,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic       word_end,
  output logic       word_cut
);

  logic                       job_push;
  twe_pkg::job_t              job_in;
  logic                       job_full;
  logic                       job_valid;
  twe_pkg::job_t              job_head;
  logic                       job_pop;
  twe_pkg::done_t             done;
  logic                       ram_we;
  logic [twe_pkg::ADDR_W-1:0] ram_waddr;
  logic [7:0]                 ram_wdata;
  logic                       ram_re;
  logic [twe_pkg::ADDR_W-1:0] ram_raddr;
  logic [7:0]                 ram_rdata;
  twe_pkg::res_t              res_head;

  // classify and store
  twe_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .text_byte (text_byte),
    .full      (full),
    .job_push  (job_push),
    .job       (job_in),
    .job_full  (job_full),
    .done      (done),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata)
  );

  // finished words
  twe_job_fifo u_jobs (
    .clk   (clk),
    .rst   (rst),
    .push  (job_push),
    .wdata (job_in),
    .full  (job_full),
    .valid (job_valid),
    .rdata (job_head),
    .pop   (job_pop)
  );

  // two word buffers
  twe_ram #(
    .WIDTH (8),
    .DEPTH (twe_pkg::RAM_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // emit words
  twe_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job_head  (job_head),
    .job_pop   (job_pop),
    .done      (done),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .empty     (empty),
    .pop       (pop),
    .head      (res_head)
  );

  assign out_byte = res_head.data;
  assign word_end = res_head.word_end;
  assign word_cut = res_head.word_cut;

endmodule
